### design/gsm7p_pkg.sv
// ----------------------------------------------------------------------------
// gsm7p_pkg
// Shared types, codes and the ASCII to GSM 7-bit default alphabet table.
// ----------------------------------------------------------------------------
package gsm7p_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNENC    = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  localparam logic [6:0] GSM_ESC  = 7'h1B;
  localparam logic [7:0] NO_CODE  = 8'hFF;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam int unsigned REG_LEAD_BITS = 0;
  localparam int unsigned REG_CAPACITY  = 1;

  // Bit 7 set marks an extension character: escape first, then bits 6:0.
  localparam logic [7:0] GSM_MAP [128] = '{
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'hFF,8'h0A,8'hFF,8'hFF,8'h0D,8'hFF,8'hFF,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'h20,8'h21,8'h22,8'h23,8'h02,8'h25,8'h26,8'h27,
    8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h2D,8'h2E,8'h2F,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
    8'h38,8'h39,8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,
    8'h00,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
    8'h48,8'h49,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,
    8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5A,8'hBC,8'hAF,8'hBE,8'h94,8'h11,
    8'hFF,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,
    8'h68,8'h69,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,
    8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,
    8'h78,8'h79,8'h7A,8'hA8,8'hC0,8'hA9,8'hBD,8'hFF
  };

  typedef struct packed {
    logic [2:0] lead_bits;
    logic [7:0] capacity_octets;
  } cfg_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       end_of_message;
    logic [1:0] status;
    logic [8:0] septet_count;
  } result_t;

  // Up to three result words from one character.
  typedef struct packed {
    logic [1:0]          n;
    result_t [2:0]       r;
  } push_t;

endpackage

### design/gsm7p_if.sv
// ----------------------------------------------------------------------------
// gsm7p_in_if / gsm7p_out_if
// Valid/ready channels for characters in and packed octets out.
// ----------------------------------------------------------------------------
interface gsm7p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface gsm7p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       end_of_message;
  logic [1:0] status;
  logic [8:0] septet_count;

  modport source (output valid, output packed_byte, output end_of_message,
                  output status, output septet_count, input ready);
  modport sink   (input valid, input packed_byte, input end_of_message,
                  input status, input septet_count, output ready);
endinterface

### design/gsm7_text_encoder_packer_top.sv
// ----------------------------------------------------------------------------
// gsm7_text_encoder_packer_top
// ASCII to GSM 7-bit encoder with LSB-first septet packing into octets.
// ----------------------------------------------------------------------------
// Path: a character is held in the character register, then its words are
//   written to the result queue, from which the first word is offered.
// Throughput: one character per cycle while each gives at most one word and
//   byte_out.ready stays high; the single output port of the result queue
//   drains one word a cycle, so characters giving two or three words stall.
// Reset (rst, synchronous): message state and queue cleared, lead_bits 0,
//   capacity_octets 140.
module gsm7_text_encoder_packer_top (
  input  logic         clk,
  input  logic         rst,
  gsm7p_in_if.sink     char_in,
  gsm7p_out_if.source  byte_out,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import gsm7p_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  room;

  gsm7p_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsm7p_core u_core (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .cfg     (cfg),
    .room    (room),
    .push    (push)
  );

  gsm7p_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .byte_out (byte_out)
  );

endmodule

### design/gsm7p_cfg.sv
// ----------------------------------------------------------------------------
// gsm7p_cfg
// APB register file: fill bit count and octet capacity.
// ----------------------------------------------------------------------------
module gsm7p_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gsm7p_pkg::cfg_t    cfg
);
  import gsm7p_pkg::*;

  logic [2:0] lead_bits;
  logic [7:0] capacity_octets;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_bits       <= 3'd0;
      capacity_octets <= 8'd140;
    end else if (wr_en) begin
      if (32'(paddr[2]) == REG_LEAD_BITS) begin
        lead_bits <= pwdata[2:0];
      end else begin
        capacity_octets <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (32'(paddr[2]) == REG_LEAD_BITS) begin
      prdata = {29'd0, lead_bits};
    end else begin
      prdata = {24'd0, capacity_octets};
    end
  end

  assign cfg.lead_bits       = lead_bits;
  assign cfg.capacity_octets = capacity_octets;

endmodule

### design/gsm7p_core.sv
// ----------------------------------------------------------------------------
// gsm7p_core
// Character register, table lookup, septet packing and message state.
// ----------------------------------------------------------------------------
module gsm7p_core (
  input  logic              clk,
  input  logic              rst,
  gsm7p_in_if.sink          char_in,
  input  gsm7p_pkg::cfg_t   cfg,
  input  logic              room,
  output gsm7p_pkg::push_t  push
);
  import gsm7p_pkg::*;

  // held character
  logic       item_vld;
  logic [7:0] item_char;
  logic       item_last;

  // message state
  logic [6:0] hold;
  logic [2:0] hold_cnt;
  logic [7:0] oct_cnt;
  logic [8:0] sep_cnt;
  logic       dropping;
  logic       at_start;

  logic       adv;
  logic [6:0] st_hold;
  logic [2:0] st_cnt;
  logic [7:0] st_oct;
  logic [8:0] st_sep;
  logic       st_drop;

  logic [7:0]  g;
  logic        unenc;
  logic        ext;
  logic [13:0] sep_bits;
  logic [1:0]  nsep;
  logic [4:0]  nbits;
  logic [23:0] acc;
  logic [4:0]  total;
  logic [1:0]  full;
  logic [2:0]  rem;
  logic        flush;
  logic [1:0]  nocts;
  logic        cap_err;
  logic        err;
  logic [9:0]  sep_sum;
  logic [8:0]  new_sep;
  logic [6:0]  hold_next;

  assign adv           = item_vld && room;
  assign char_in.ready = !item_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (char_in.ready) begin
      item_vld <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      item_char <= char_in.char_code;
      item_last <= char_in.last_char;
    end
  end

  // Message start loads the fill count and clears the rest.
  always_comb begin
    if (at_start) begin
      st_hold = 7'd0;
      st_cnt  = cfg.lead_bits;
      st_oct  = 8'd0;
      st_sep  = 9'd0;
      st_drop = 1'b0;
    end else begin
      st_hold = hold;
      st_cnt  = hold_cnt;
      st_oct  = oct_cnt;
      st_sep  = sep_cnt;
      st_drop = dropping;
    end
  end

  assign g        = GSM_MAP[item_char[6:0]];
  assign unenc    = item_char[7] || (g == NO_CODE);
  assign ext      = g[7];
  assign sep_bits = ext ? {g[6:0], GSM_ESC} : {7'd0, g[6:0]};
  assign nsep     = ext ? 2'd2 : 2'd1;
  assign nbits    = ext ? 5'd14 : 5'd7;
  assign acc      = {17'd0, st_hold} | ({10'd0, sep_bits} << st_cnt);
  assign total    = {2'b00, st_cnt} + nbits;
  assign full     = total[4:3];
  assign rem      = total[2:0];
  assign flush    = item_last && (rem != 3'd0);
  assign nocts    = full + {1'b0, flush};
  assign cap_err  = ({1'b0, st_oct} + {7'd0, nocts}) > {1'b0, cfg.capacity_octets};
  assign err      = unenc || cap_err;
  assign sep_sum  = {1'b0, st_sep} + {8'd0, nsep};
  assign new_sep  = sep_sum[9] ? 9'd511 : sep_sum[8:0];

  always_comb begin
    unique case (full)
      2'd0:    hold_next = acc[6:0];
      2'd1:    hold_next = acc[14:8];
      default: hold_next = acc[22:16];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold     <= 7'd0;
      hold_cnt <= 3'd0;
      oct_cnt  <= 8'd0;
      sep_cnt  <= 9'd0;
      dropping <= 1'b0;
      at_start <= 1'b1;
    end else if (adv) begin
      at_start <= item_last;
      if (st_drop || err) begin
        hold     <= st_hold;
        hold_cnt <= st_cnt;
        oct_cnt  <= st_oct;
        sep_cnt  <= st_sep;
        dropping <= st_drop || !item_last;
      end else begin
        hold     <= hold_next;
        hold_cnt <= rem;
        oct_cnt  <= st_oct + {6'd0, nocts};
        sep_cnt  <= new_sep;
        dropping <= 1'b0;
      end
    end
  end

  always_comb begin
    push.n = 2'd0;
    for (int k = 0; k < 3; k++) begin
      push.r[k].packed_byte    = acc[8*k +: 8];
      push.r[k].end_of_message = item_last && (nocts == 2'(k + 1));
      push.r[k].status         = ST_OK;
      push.r[k].septet_count   = new_sep;
    end
    if (adv && !st_drop) begin
      if (err) begin
        push.n                   = 2'd1;
        push.r[0].packed_byte    = 8'd0;
        push.r[0].end_of_message = 1'b1;
        push.r[0].status         = unenc ? ST_UNENC : ST_CAPACITY;
        push.r[0].septet_count   = st_sep;
      end else begin
        push.n = nocts;
      end
    end
  end

endmodule

### design/gsm7p_queue.sv
// ----------------------------------------------------------------------------
// gsm7p_queue
// Four-entry result queue: takes up to three words a cycle, sends one.
// ----------------------------------------------------------------------------
module gsm7p_queue (
  input  logic              clk,
  input  logic              rst,
  input  gsm7p_pkg::push_t  push,
  output logic              room,
  gsm7p_out_if.source       byte_out
);
  import gsm7p_pkg::*;

  result_t             q [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;

  // Room for a full three-word burst.
  assign room = count <= QCNT_W'(QDEPTH - 3);
  assign pop  = byte_out.valid && byte_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push.n);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.n) begin
        q[wptr + QPTR_W'(k)] <= push.r[k];
      end
    end
  end

  assign byte_out.valid          = count != '0;
  assign byte_out.packed_byte    = q[rptr].packed_byte;
  assign byte_out.end_of_message = q[rptr].end_of_message;
  assign byte_out.status         = q[rptr].status;
  assign byte_out.septet_count   = q[rptr].septet_count;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the GSM 7-bit encoder and octet packer. Characters
// go in over a valid/ready channel with random gaps. A behavioural packer in
// the bench predicts every packed word, and a checker compares each arriving
// word field by field. The bench covers directed text, escape characters,
// unencodable codes, capacity limits, several register settings, random
// messages and a long back-pressure stretch.
// ----------------------------------------------------------------------------
module testbench;
  import gsm7p_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic rx_ready = 1'b0;

  gsm7p_in_if  char_ch ();
  gsm7p_out_if byte_ch ();

  assign byte_ch.ready = rx_ready;

  gsm7_text_encoder_packer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_ch),
    .byte_out (byte_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Packer model state and its copy of the registers
  cfg_t        shadow_cfg = '{lead_bits: 3'd0, capacity_octets: 8'd140};
  logic [6:0]  hold_bits  = '0;
  int unsigned hold_cnt   = 0;
  int unsigned octs_out   = 0;
  int unsigned septs_out  = 0;
  bit          skip_rest  = 1'b0;
  bit          msg_start  = 1'b1;

  result_t     octet_q [$];
  int unsigned n_errors   = 0;
  int unsigned cycle_cnt  = 0;
  bit          idle_on    = 1'b1;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  task automatic queue_word(input logic [7:0] b, input logic eom, input logic [1:0] st,
                            input int unsigned cnt);
    result_t w;
    w.packed_byte    = b;
    w.end_of_message = eom;
    w.status         = st;
    w.septet_count   = cnt[8:0];
    octet_q.push_back(w);
  endtask

  // Work out the words one accepted character gives and queue them
  task automatic pack_char(input logic [7:0] code, input logic last);
    logic [7:0]  g;
    logic [6:0]  sep [2];
    logic [7:0]  octs [3];
    logic [15:0] acc;
    int unsigned nsep;
    int unsigned nocts;
    int unsigned cnt;
    int unsigned newcount;
    logic [1:0]  st;
    if (msg_start) begin
      hold_cnt  = shadow_cfg.lead_bits;
      hold_bits = '0;
      octs_out  = 0;
      septs_out = 0;
      skip_rest = 1'b0;
      msg_start = 1'b0;
    end
    if (skip_rest) begin
      if (last) msg_start = 1'b1;
      return;
    end
    st = ST_OK;
    if (code[7] || GSM_MAP[code[6:0]] == NO_CODE) begin
      st = ST_UNENC;
    end else begin
      g     = GSM_MAP[code[6:0]];
      nsep  = 0;
      nocts = 0;
      if (g[7]) begin
        sep[0] = GSM_ESC;
        sep[1] = g[6:0];
        nsep   = 2;
      end else begin
        sep[0] = g[6:0];
        nsep   = 1;
      end
      acc = {9'd0, hold_bits};
      cnt = hold_cnt;
      for (int i = 0; i < nsep; i++) begin
        acc = acc | (16'(sep[i]) << cnt);
        cnt = cnt + 7;
        while (cnt >= 8) begin
          octs[nocts] = acc[7:0];
          nocts = nocts + 1;
          acc   = acc >> 8;
          cnt   = cnt - 8;
        end
      end
      // flush the partial octet on the final character
      if (last && cnt > 0) begin
        octs[nocts] = acc[7:0];
        nocts = nocts + 1;
        acc   = '0;
        cnt   = 0;
      end
      if (octs_out + nocts > shadow_cfg.capacity_octets) begin
        st = ST_CAPACITY;
      end else begin
        newcount = septs_out + nsep;
        if (newcount > 511) newcount = 511;
        for (int i = 0; i < nocts; i++)
          queue_word(octs[i], last && (i + 1 == nocts), ST_OK, newcount);
        octs_out  = octs_out + nocts;
        septs_out = newcount;
        hold_bits = acc[6:0];
        hold_cnt  = cnt;
        if (last) msg_start = 1'b1;
        return;
      end
    end
    queue_word(8'h00, 1'b1, st, septs_out);
    if (last) msg_start = 1'b1;
    else skip_rest = 1'b1;
  endtask

  // Offer one character after a random gap while idle_on is set; hold valid high until accepted
  task automatic send_char(input logic [7:0] code, input logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= code;
    char_ch.last_char <= last;
    do @(posedge clk); while (!char_ch.ready);
    pack_char(code, last);
  endtask

  task automatic send_text(input logic [7:0] text [], input bit ends);
    for (int i = 0; i < text.size(); i++)
      send_char(text[i], ends && (i == text.size() - 1));
  endtask

  // Drop valid and wait until every expected word is in, then let the block settle
  task automatic drain();
    char_ch.valid <= 1'b0;
    while (octet_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LEAD_BITS) shadow_cfg.lead_bits = value[2:0];
    else if (idx == REG_CAPACITY) shadow_cfg.capacity_octets = value[7:0];
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == 8'h60) c = 8'h61;
    end else if (r < 85) begin
      case ($urandom_range(0, 7))
        0: c = 8'h5B;
        1: c = 8'h5C;
        2: c = 8'h5D;
        3: c = 8'h5E;
        4: c = 8'h7B;
        5: c = 8'h7C;
        6: c = 8'h7D;
        default: c = 8'h7E;
      endcase
    end else if (r < 95) begin
      case ($urandom_range(0, 4))
        0: c = 8'h0A;
        1: c = 8'h0D;
        2: c = 8'h40;
        3: c = 8'h24;
        default: c = 8'h5F;
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic send_random_message(input int unsigned len);
    for (int i = 0; i < len; i++)
      send_char(pick_char(), i == len - 1);
  endtask

  task automatic test_plain_chars();
    send_text('{8'h40, 8'h24, 8'h5F, 8'h0A, 8'h0D, 8'h7A}, 1'b1);
    drain();
  endtask

  task automatic test_escape_chars();
    write_reg(REG_LEAD_BITS, 32'd7);
    send_text('{8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h7B, 8'h7C, 8'h7D, 8'h7E}, 1'b1);
    drain();
  endtask

  task automatic test_unencodable();
    // error mid-message, then the rest is dropped up to the last character
    send_text('{8'h41, 8'h60, 8'h42, 8'h43}, 1'b1);
    send_text('{8'h00}, 1'b1);
    send_text('{8'h80, 8'hFF}, 1'b1);
    send_text('{8'h7F}, 1'b1);
    drain();
  endtask

  task automatic test_capacity();
    write_reg(REG_CAPACITY, 32'd0);
    send_text('{8'h41}, 1'b1);
    drain();
    write_reg(REG_LEAD_BITS, 32'd0);
    write_reg(REG_CAPACITY, 32'd1);
    send_text('{8'h41, 8'h42, 8'h43, 8'h44}, 1'b1);
    drain();
  endtask

  task automatic test_random_text();
    int unsigned sent;
    int unsigned len;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_LEAD_BITS, 32'd0); write_reg(REG_CAPACITY, 32'd255); end
        1: begin write_reg(REG_LEAD_BITS, 32'd7); write_reg(REG_CAPACITY, 32'd140); end
        2: begin
          write_reg(REG_LEAD_BITS, $urandom_range(0, 7));
          write_reg(REG_CAPACITY, $urandom_range(1, 6));
        end
        3: begin
          write_reg(REG_LEAD_BITS, $urandom_range(0, 7));
          write_reg(REG_CAPACITY, $urandom_range(20, 255));
        end
        4: begin write_reg(REG_LEAD_BITS, 32'd3); write_reg(REG_CAPACITY, 32'd0); end
        default: begin
          write_reg(REG_LEAD_BITS, $urandom_range(0, 7));
          write_reg(REG_CAPACITY, $urandom_range(0, 255));
        end
      endcase
      sent = 0;
      while (sent < ((ph == 4) ? 4 : 10)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 8);
        send_random_message(len);
        sent = sent + len;
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_LEAD_BITS, 32'd5);
    write_reg(REG_CAPACITY, 32'd255);
    idle_on   = 1'b0;
    hold_left = 80;
    // escapes give two septets a character, mostly two words, so the result queue fills fast
    for (int m = 0; m < 3; m++)
      send_text('{8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h7C, 8'h41, 8'h7E, 8'h5C}, 1'b1);
    drain();
    idle_on = 1'b1;
  endtask

  // Receiver: check each accepted word, then stall for a random count while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      rx_ready   <= 1'b0;
      stall_left = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        check_word();
        stall_left = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rx_ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        rx_ready   <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  task automatic check_word();
    result_t want;
    if (octet_q.size() == 0) begin
      $error("unexpected word: packed_byte %0h status %0d", byte_ch.packed_byte, byte_ch.status);
      n_errors++;
      return;
    end
    want = octet_q.pop_front();
    if (byte_ch.packed_byte !== want.packed_byte) begin
      $error("packed_byte: expected %0h, actual %0h", want.packed_byte, byte_ch.packed_byte);
      n_errors++;
    end
    if (byte_ch.end_of_message !== want.end_of_message) begin
      $error("end_of_message: expected %0b, actual %0b", want.end_of_message,
             byte_ch.end_of_message);
      n_errors++;
    end
    if (byte_ch.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, byte_ch.status);
      n_errors++;
    end
    if (byte_ch.septet_count !== want.septet_count) begin
      $error("septet_count: expected %0d, actual %0d", want.septet_count,
             byte_ch.septet_count);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    char_ch.last_char = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_plain_chars();
    test_escape_chars();
    test_unencodable();
    test_capacity();
    test_random_text();
    test_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0 && octet_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (octet_q.size() != 0) $error("words still expected at end: %0d", octet_q.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
